@@ rtl/core/mjfs_pkg.sv @@
// shared types and constants for the multipart jpeg frame splitter
package mjfs_pkg;

    // longest boundary string and depth of the frame delay line
    localparam int MAX_BOUNDARY = 32;
    localparam int HIST_DEPTH   = MAX_BOUNDARY + 2;

    // widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int LIDX_W   = $clog2(MAX_BOUNDARY);
    localparam int FILL_W   = $clog2(HIST_DEPTH + 1);
    localparam int OFF_W    = 4;
    localparam int WORD_W   = 64;
    localparam int BND_WORDS = 4;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // stream constants
    localparam logic [BYTE_W-1:0] SOI_BYTE       = 8'hFF;
    localparam logic [OFF_W-1:0]  CHANNEL_OFFSET = 4'd14;
    localparam logic [OFF_W-1:0]  OFFSET_MAX     = 4'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD0        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD1        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD2        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD3        = 3'd4;

    // splitter modes
    typedef enum logic [1:0] {
        MODE_SEEK   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_FILL   = 2'd2,
        MODE_FLOW   = 2'd3
    } t_mode;

    // one delay line entry: frame byte plus frame start tag
    typedef struct packed {
        logic              tag;
        logic [BYTE_W-1:0] data;
    } t_entry;

endpackage

@@ rtl/core/mjfs_data_cell.sv @@
// one stage of the frame delay line, shifts toward the older end on push
module mjfs_data_cell
    import mjfs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_prev,
    output t_entry o_entry
);

    t_entry r_entry;

    // take the neighbor's entry on every push
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/core/mjfs_match_cell.sv @@
// one boundary compare cell: extends the window match of its newer neighbor by one byte
module mjfs_match_cell
    import mjfs_pkg::*;
(
    input  logic              i_prefix,
    input  logic              i_use,
    input  logic [BYTE_W-1:0] i_win_byte,
    input  logic [BYTE_W-1:0] i_bnd_byte,
    output logic              o_match
);

    // positions beyond the boundary length pass the prefix match through unchanged
    assign o_match = i_prefix & (!i_use | (i_win_byte == i_bnd_byte));

endmodule

@@ rtl/core/multipart_jpeg_frame_splitter_core.sv @@
// top level of the multipart jpeg frame splitter
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata[7:0] in_byte
//  m_axis    out  m_axis_tvalid/tready        tdata out_byte, frame_channel;
//                                             tuser byte_valid, frame_start;
//                                             tlast frame_end
//  cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// one byte per clock unless the output stalls; every byte is handled in the cycle it is
// accepted and its result, if any, lands in the output register on the same edge.
// the window compare runs as a chain of compare cells, one per boundary byte,
// each checking one window byte, and frame bytes move through a 34-stage
// delay line of data cells.
// reset is synchronous: seeking mode, empty line, length 1, boundary zero.
// a held result does not block input while m_axis_tready takes it this cycle.
module multipart_jpeg_frame_splitter_core
    import mjfs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [15:8] frame_channel
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] byte_valid, [1] frame_start
    output logic                   m_axis_tlast,   // frame_end
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data
);

    // configuration registers
    logic [LEN_W-1:0]                  r_len;
    logic [BND_WORDS-1:0][WORD_W-1:0]  r_bnd_word;

    // splitter state
    t_mode             r_mode,   n_mode;
    logic [FILL_W-1:0] r_fill,   n_fill;
    logic [OFF_W-1:0]  r_offset, n_offset;
    logic [BYTE_W-1:0] r_held,   n_held;

    // output register
    logic              r_ov;
    logic [BYTE_W-1:0] r_obyte,  n_obyte;
    logic              r_obv,    n_obv;
    logic              r_ostart, n_ostart;
    logic              r_oend,   n_oend;
    logic [BYTE_W-1:0] r_ochan,  n_ochan;
    logic              n_emit;

    logic              w_acc;
    logic [BYTE_W-1:0] w_in;
    logic [LIDX_W-1:0] w_lenm1;
    logic [FILL_W-1:0] w_need;
    logic              w_full_line;
    logic              w_win_ok;
    logic              w_hit;
    t_entry            w_first;
    t_entry            w_oldest;
    logic              w_push;
    logic [BYTE_W-1:0] w_tk_held;
    logic [OFF_W-1:0]  w_tk_off;
    logic [FILL_W-1:0] w_fill_inc;

    t_entry            w_ent      [HIST_DEPTH];
    logic              w_match    [MAX_BOUNDARY];
    logic [BYTE_W-1:0] w_bnd_byte [MAX_BOUNDARY];

    assign w_in          = s_axis_tdata[BYTE_W-1:0];
    assign s_axis_tready = !r_ov || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_W'(1);
            r_bnd_word <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BOUNDARY_LEN: r_len         <= i_cfg_data[LEN_W-1:0];
                CFG_WORD0:        r_bnd_word[0] <= i_cfg_data;
                CFG_WORD1:        r_bnd_word[1] <= i_cfg_data;
                CFG_WORD2:        r_bnd_word[2] <= i_cfg_data;
                CFG_WORD3:        r_bnd_word[3] <= i_cfg_data;
                default:          r_len         <= r_len;
            endcase
        end
    end

    // effective boundary length minus one, clamped to 1..MAX_BOUNDARY
    always_comb begin
        if (r_len == '0) begin
            w_lenm1 = '0;
        end else if (r_len > LEN_W'(MAX_BOUNDARY)) begin
            w_lenm1 = LIDX_W'(MAX_BOUNDARY - 1);
        end else begin
            w_lenm1 = LIDX_W'(r_len - LEN_W'(1));
        end
    end

    // line holds boundary plus two bytes: oldest byte leaves
    assign w_need      = FILL_W'(w_lenm1) + FILL_W'(3);
    assign w_full_line = r_fill >= w_need;

    // enough history for the boundary minus its final byte
    assign w_win_ok    = r_fill >= FILL_W'(w_lenm1);
    assign w_hit       = w_match[MAX_BOUNDARY-1];

    // boundary bytes in string order
    for (genvar k = 0; k < MAX_BOUNDARY; k++) begin : g_bnd
        assign w_bnd_byte[k] =
            r_bnd_word[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
    end

    // compare cell chain: cell k checks the byte k places back against the boundary tail
    for (genvar k = 0; k < MAX_BOUNDARY; k++) begin : g_match
        logic              w_prefix;
        logic [BYTE_W-1:0] w_win;
        logic [LIDX_W-1:0] w_bidx;
        if (k == 0) begin : g_head
            assign w_prefix = w_win_ok;
            assign w_win    = w_in;
        end else begin : g_body
            assign w_prefix = w_match[k-1];
            assign w_win    = w_ent[k-1].data;
        end
        assign w_bidx = w_lenm1 - LIDX_W'(k);
        mjfs_match_cell u_cell (
            .i_prefix   (w_prefix),
            .i_use      (LIDX_W'(k) <= w_lenm1),
            .i_win_byte (w_win),
            .i_bnd_byte (w_bnd_byte[w_bidx]),
            .o_match    (w_match[k])
        );
    end

    // frame delay line, newest entry in cell 0
    assign w_first.data = w_in;
    assign w_first.tag  = (r_mode == MODE_HEADER);

    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_line
        t_entry w_prev;
        if (k == 0) begin : g_head
            assign w_prev = w_first;
        end else begin : g_body
            assign w_prev = w_ent[k-1];
        end
        mjfs_data_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_push),
            .i_prev  (w_prev),
            .o_entry (w_ent[k])
        );
    end

    // oldest held entry sits at position fill-1
    always_comb begin
        w_oldest = '0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            if (r_fill == FILL_W'(k + 1)) begin
                w_oldest = w_oldest | w_ent[k];
            end
        end
    end

    // channel capture at frame offset 14
    assign w_tk_held  = (r_offset == CHANNEL_OFFSET) ? w_in : r_held;
    assign w_tk_off   = (r_offset == OFFSET_MAX) ? r_offset : r_offset + OFF_W'(1);
    assign w_fill_inc = (r_fill == FILL_W'(HIST_DEPTH)) ? r_fill : r_fill + FILL_W'(1);

    // splitter state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SEEK;
            r_fill   <= '0;
            r_offset <= '0;
            r_held   <= '0;
        end else begin
            r_mode   <= n_mode;
            r_fill   <= n_fill;
            r_offset <= n_offset;
            r_held   <= n_held;
        end
    end

    // next state and result per accepted byte
    always_comb begin
        n_mode      = r_mode;
        n_fill      = r_fill;
        n_offset    = r_offset;
        n_held      = r_held;
        w_push      = 1'b0;
        n_emit      = 1'b0;
        n_obyte     = '0;
        n_obv       = 1'b0;
        n_ostart    = 1'b0;
        n_oend      = 1'b0;
        n_ochan     = '0;
        if (w_acc) begin
            case (r_mode)
                MODE_SEEK: begin
                    if (w_hit) begin
                        n_fill      = '0;
                        n_mode      = MODE_HEADER;
                    end else begin
                        w_push     = 1'b1;
                        n_fill     = w_fill_inc;
                    end
                end
                MODE_HEADER: begin
                    if (w_in == SOI_BYTE) begin
                        w_push     = 1'b1;
                        n_fill     = FILL_W'(1);
                        n_offset   = OFF_W'(1);
                        n_held     = '0;
                        n_mode     = MODE_FILL;
                    end
                end
                MODE_FILL, MODE_FLOW: begin
                    n_held   = w_tk_held;
                    n_offset = w_tk_off;
                    if (w_full_line) begin
                        n_obyte  = w_oldest.data;
                        n_obv    = 1'b1;
                        n_ostart = w_oldest.tag;
                    end
                    if (w_hit) begin
                        n_fill      = '0;
                        n_offset    = '0;
                        n_mode      = MODE_HEADER;
                        n_emit      = w_full_line || (r_mode == MODE_FLOW);
                        n_oend      = 1'b1;
                        n_ochan     = w_tk_held;
                    end else begin
                        w_push     = 1'b1;
                        if (w_full_line) begin
                            n_emit = 1'b1;
                            n_mode = MODE_FLOW;
                        end else begin
                            n_fill = w_fill_inc;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_SEEK;
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_acc) begin
            r_ov <= n_emit;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_acc && n_emit) begin
            r_obyte  <= n_obyte;
            r_obv    <= n_obv;
            r_ostart <= n_ostart;
            r_oend   <= n_oend;
            r_ochan  <= n_ochan;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_ochan, r_obyte};
    assign m_axis_tuser  = {r_ostart, r_obv};
    assign m_axis_tlast  = r_oend;

endmodule

@@ rtl/core/mjfs_checker.sv @@
// port-level assertions for the frame splitter, bound to the top level
module mjfs_checker
    import mjfs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // frame start is always a real 0xff byte
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]
        && (m_axis_tdata[BYTE_W-1:0] == SOI_BYTE))
        else $error("frame start without start-of-image byte");

    // a result without data only closes a frame
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast
        && (m_axis_tdata[BYTE_W-1:0] == '0))
        else $error("empty result that does not close a frame");

    // channel only shown on the closing transaction
    a_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[OUT_TDATA_W-1:BYTE_W] == '0))
        else $error("channel reported before frame end");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind multipart_jpeg_frame_splitter_core mjfs_checker u_mjfs_checker (.*);
